### design/phsa_pkg.sv
// Shared types, constants and register codes for the pH sensor averaging block.
`timescale 1ns / 1ps

package phsa_pkg;

  localparam int PH_W       = 14;
  localparam int CODE_W     = 12;
  localparam int OFFSET_W   = 22;
  localparam int SLOPE_W    = 16;
  localparam int VOLT_W     = 9;
  localparam int DROP_W     = SLOPE_W + VOLT_W;
  localparam int LOWCNT_W   = 8;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 22;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  localparam logic [PH_W-1:0] PH_MAX = PH_W'(14336);

  localparam logic [OFFSET_W-1:0] OFFSET_RST = OFFSET_W'(1428553);
  localparam logic [SLOPE_W-1:0]  SLOPE_RST  = SLOPE_W'(6442);
  localparam logic [PH_W-1:0]     WARN_RST   = PH_W'(6656);
  localparam logic [PH_W-1:0]     OK_RST     = PH_W'(6963);

  localparam logic [LOWCNT_W-1:0] LOWCNT_MAX = '1;

  // Voltage units are 330*code/4095, taken as a reciprocal multiply.
  localparam int VOLT_SHIFT = 24;
  localparam int VOLT_RECIP_W = 21;
  localparam logic [VOLT_RECIP_W-1:0] VOLT_RECIP =
    VOLT_RECIP_W'((64'd330 * 64'd16777216 + 64'd4094) / 64'd4095);

  localparam int WINDOW_DEF = 20;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PH_OFFSET  = 8'd0,
    REG_PH_SLOPE   = 8'd1,
    REG_WARN_LEVEL = 8'd2,
    REG_OK_LEVEL   = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic warn_user;
    logic notify_update;
    logic pump_request;
  } alarm_stat_t;

endpackage

### design/phsa_ifs.sv
// Handshake channel interfaces for sample input, result output and configuration.
`timescale 1ns / 1ps

interface phsa_in_if
  import phsa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [CODE_W-1:0] adc_sample;

  modport source (output valid, output opcode, output adc_sample, input ready);
  modport sink (input valid, input opcode, input adc_sample, output ready);
endinterface

interface phsa_out_if
  import phsa_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [PH_W-1:0] ph_average;
  logic            average_valid;
  logic [PH_W-1:0] latest_ph;
  logic            warn_user;
  logic            notify_update;
  logic            pump_request;

  modport source (output valid, output ph_average, output average_valid, output latest_ph,
                  output warn_user, output notify_update, output pump_request, input ready);
  modport sink (input valid, input ph_average, input average_valid, input latest_ph,
                input warn_user, input notify_update, input pump_request, output ready);
endinterface

interface phsa_cfg_if
  import phsa_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

### design/phsa_cell.sv
// One window cell: holds a pH sample and passes it to the next cell on a shift.
`timescale 1ns / 1ps

module phsa_cell
  import phsa_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  logic [PH_W-1:0] d_in,
  output logic [PH_W-1:0] q_out
);

  logic [PH_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (shift_en) begin
      val_r <= d_in;
    end
  end

  assign q_out = val_r;

endmodule

### design/phsa_window.sv
// Sample window as a row of cells with a running sum and a fill counter.
`timescale 1ns / 1ps

module phsa_window
  import phsa_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  parameter int SUM_W  = $clog2(WINDOW * 14336 + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  logic [PH_W-1:0]  ph_in,
  output logic [SUM_W-1:0] sum,
  output logic             full
);

  localparam int CNT_W = $clog2(WINDOW + 1);

  logic [PH_W-1:0]  tap [WINDOW+1];
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign tap[0] = ph_in;

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    phsa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (tap[g]),
      .q_out    (tap[g+1])
    );
  end

  always_comb begin
    sum_nxt  = sum_r;
    fill_nxt = fill_r;
    if (shift_en) begin
      sum_nxt = sum_r - SUM_W'(tap[WINDOW]) + SUM_W'(ph_in);
      if (fill_r != CNT_W'(WINDOW)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      fill_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign sum  = sum_r;
  assign full = (fill_r == CNT_W'(WINDOW));

endmodule

### design/phsa_alarm.sv
// Low-pH alarm with a run counter, warning pulses and a hysteretic pump request.
`timescale 1ns / 1ps

module phsa_alarm
  import phsa_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            check_en,
  input  logic [PH_W-1:0] ph,
  input  logic [PH_W-1:0] warn_level,
  input  logic [PH_W-1:0] ok_level,
  output alarm_stat_t     stat
);

  logic [PH_W-1:0]     prev_r;
  logic [LOWCNT_W-1:0] low_cnt_r, low_cnt_nxt;
  logic                pump_r, pump_nxt;
  logic                first_r;
  logic                warn_r, warn_nxt;
  logic                notify_r, notify_nxt;
  logic                low, old_low;

  always_comb begin
    low         = ph < warn_level;
    old_low     = prev_r < warn_level;
    low_cnt_nxt = low_cnt_r;
    pump_nxt    = pump_r;
    warn_nxt    = 1'b0;
    notify_nxt  = 1'b0;
    if ((first_r && low) || (!old_low && low)) begin
      low_cnt_nxt = LOWCNT_W'(1);
    end
    if (old_low && low) begin
      if (low_cnt_nxt != LOWCNT_MAX) begin
        low_cnt_nxt = low_cnt_nxt + 1'b1;
      end
      if (low_cnt_nxt == LOWCNT_W'(2)) begin
        warn_nxt = 1'b1;
      end
      if (low_cnt_nxt == LOWCNT_W'(3)) begin
        warn_nxt = 1'b1;
        if (!pump_r) begin
          pump_nxt   = 1'b1;
          notify_nxt = 1'b1;
        end
      end
    end
    if (ph > ok_level && pump_nxt) begin
      pump_nxt   = 1'b0;
      notify_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      low_cnt_r <= '0;
      pump_r    <= 1'b0;
      first_r   <= 1'b1;
      warn_r    <= 1'b0;
      notify_r  <= 1'b0;
    end else if (check_en) begin
      prev_r    <= ph;
      low_cnt_r <= low_cnt_nxt;
      pump_r    <= pump_nxt;
      first_r   <= 1'b0;
      warn_r    <= warn_nxt;
      notify_r  <= notify_nxt;
    end
  end

  assign stat.warn_user     = warn_r;
  assign stat.notify_update = notify_r;
  assign stat.pump_request  = pump_r;

endmodule

### design/ph_sensor_average_and_alarm.sv
// Top level of the pH sensor averaging and low-pH alarm block.
//
// The input channel carries an opcode and a 12-bit converter code. Opcode 0
// is a sample: the code becomes a Q10 pH value that enters a WINDOW-deep row
// of cells with a running sum, and the window average is published once the
// row has filled. Opcode 1 is an alarm check on the published average.
// Every input transfer yields exactly one transfer on the result channel.
// Configuration writes arrive on their own channel, which is always ready,
// and must only be issued while the block is idle.
// One item is processed at a time. From its transfer until its result is
// loaded into the output register, a sample passes through voltage multiply,
// slope multiply, window shift, reciprocal multiply for the average, publish
// and load, in that order. A check passes through the alarm update and load.
// The input is ready again in the cycle after the result is loaded, even if
// the receiver has not yet taken it; a stalled receiver holds the next result
// in its final step until the output register frees up. Reset clears the
// window cells, the sum, the alarm state and the output valid flag.
`timescale 1ns / 1ps

module ph_sensor_average_and_alarm
  import phsa_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  phsa_in_if.sink    in_ch,
  phsa_out_if.source out_ch,
  phsa_cfg_if.sink   cfg_ch
);

  localparam int SUM_W    = $clog2(WINDOW * 14336 + 1);
  localparam int AVG_K    = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W  = SUM_W + 2;
  localparam int AVG_P_W  = SUM_W + RECIP_W;
  localparam longint AVG_RECIP_L = ((longint'(1) << AVG_K) + WINDOW - 1) / WINDOW;
  localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(AVG_RECIP_L);
  localparam int VOLT_P_W = CODE_W + VOLT_RECIP_W;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_VOLT = 8'b0000_0010,
    ST_DROP = 8'b0000_0100,
    ST_WIN  = 8'b0000_1000,
    ST_AVG  = 8'b0001_0000,
    ST_PUB  = 8'b0010_0000,
    ST_CHK  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [OFFSET_W-1:0] offset_r;
  logic [SLOPE_W-1:0]  slope_r;
  logic [PH_W-1:0]     warn_lvl_r;
  logic [PH_W-1:0]     ok_lvl_r;

  logic                is_check_r;
  logic [CODE_W-1:0]   code_r;
  logic [VOLT_W-1:0]   volts_r;
  logic [DROP_W-1:0]   drop_r;
  logic [AVG_P_W-1:0]  avg_prod_r;
  logic [PH_W-1:0]     published_r;
  logic [PH_W-1:0]     last_ph_r;

  logic                out_valid_r;
  logic [PH_W-1:0]     out_avg_r;
  logic                out_avg_valid_r;
  logic [PH_W-1:0]     out_latest_r;
  logic                out_warn_r;
  logic                out_notify_r;
  logic                out_pump_r;

  logic [VOLT_P_W-1:0] volt_prod;
  logic [OFFSET_W-1:0] ph_diff;
  logic [15:0]         ph_q;
  logic [PH_W-1:0]     ph_new;
  logic [SUM_W-1:0]    win_sum;
  logic                win_full;
  logic                in_xfer;
  logic                out_free;
  alarm_stat_t         alarm_stat;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign volt_prod = code_r * VOLT_RECIP;

  always_comb begin
    ph_diff = offset_r - drop_r[OFFSET_W-1:0];
    ph_q    = ph_diff[OFFSET_W-1:6];
    if (drop_r >= DROP_W'(offset_r)) begin
      ph_new = '0;
    end else if (ph_q > 16'(PH_MAX)) begin
      ph_new = PH_MAX;
    end else begin
      ph_new = ph_q[PH_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_ch.opcode == OP_CHECK) ? ST_CHK : ST_VOLT;
        end
      end
      ST_VOLT: state_nxt = ST_DROP;
      ST_DROP: state_nxt = ST_WIN;
      ST_WIN:  state_nxt = ST_AVG;
      ST_AVG:  state_nxt = ST_PUB;
      ST_PUB:  state_nxt = ST_DONE;
      ST_CHK:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  phsa_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (state_r == ST_WIN),
    .ph_in    (ph_new),
    .sum      (win_sum),
    .full     (win_full)
  );

  phsa_alarm u_alarm (
    .clk        (clk),
    .rst_n      (rst_n),
    .check_en   (state_r == ST_CHK),
    .ph         (published_r),
    .warn_level (warn_lvl_r),
    .ok_level   (ok_lvl_r),
    .stat       (alarm_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      offset_r    <= OFFSET_RST;
      slope_r     <= SLOPE_RST;
      warn_lvl_r  <= WARN_RST;
      ok_lvl_r    <= OK_RST;
      published_r <= '0;
      last_ph_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          REG_PH_OFFSET:  offset_r   <= cfg_ch.data[OFFSET_W-1:0];
          REG_PH_SLOPE:   slope_r    <= cfg_ch.data[SLOPE_W-1:0];
          REG_WARN_LEVEL: warn_lvl_r <= cfg_ch.data[PH_W-1:0];
          REG_OK_LEVEL:   ok_lvl_r   <= cfg_ch.data[PH_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_WIN) begin
        last_ph_r <= ph_new;
      end
      if (state_r == ST_PUB && win_full) begin
        published_r <= avg_prod_r[AVG_K +: PH_W];
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      is_check_r <= (in_ch.opcode == OP_CHECK);
      code_r     <= in_ch.adc_sample;
    end
    volts_r    <= volt_prod[VOLT_SHIFT +: VOLT_W];
    drop_r     <= slope_r * volts_r;
    avg_prod_r <= win_sum * AVG_RECIP;
    if (state_r == ST_DONE && out_free) begin
      out_avg_r       <= published_r;
      out_avg_valid_r <= win_full;
      out_latest_r    <= last_ph_r;
      out_warn_r      <= is_check_r && alarm_stat.warn_user;
      out_notify_r    <= is_check_r && alarm_stat.notify_update;
      out_pump_r      <= alarm_stat.pump_request;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.ph_average    = out_avg_r;
  assign out_ch.average_valid = out_avg_valid_r;
  assign out_ch.latest_ph     = out_latest_r;
  assign out_ch.warn_user     = out_warn_r;
  assign out_ch.notify_update = out_notify_r;
  assign out_ch.pump_request  = out_pump_r;

endmodule

### design/phsa_checker.sv
// Port-level assertions for the pH sensor block and the bind that attaches them.
`timescale 1ns / 1ps

module phsa_checker
  import phsa_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [PH_W-1:0] ph_average,
  input logic            average_valid,
  input logic [PH_W-1:0] latest_ph,
  input logic            pump_request
);

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again while an item is in flight");

  a_avg_before_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !average_valid) |-> (ph_average == '0))
    else $error("average published before the window filled");

  a_ph_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ph_average <= PH_MAX && latest_ph <= PH_MAX))
    else $error("pH result outside 0 to 14");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(ph_average) && $stable(latest_ph) && $stable(pump_request)))
    else $error("stalled result changed before its transfer");

endmodule

bind ph_sensor_average_and_alarm phsa_checker u_phsa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .ph_average    (out_ch.ph_average),
  .average_valid (out_ch.average_valid),
  .latest_ph     (out_ch.latest_ph),
  .pump_request  (out_ch.pump_request)
);

### verif/tb_top.sv
// Self-checking testbench for the pH sensor averaging and low-pH alarm block.
`timescale 1ns / 1ps

module tb_top;
  import phsa_pkg::*;

  localparam int AVG_DEPTH = WINDOW_DEF;
  localparam int VOLT_FULL_SCALE = 330;
  localparam int ADC_FULL_SCALE = 4095;

  typedef enum logic [1:0] {RX_EAGER, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    logic              op;
    logic [CODE_W-1:0] code;
  } sensor_item_t;

  typedef struct packed {
    logic [PH_W-1:0] avg;
    logic            avg_ok;
    logic [PH_W-1:0] latest;
    logic            warn;
    logic            notify;
    logic            pump;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n;

  phsa_in_if  in_if ();
  phsa_out_if out_if ();
  phsa_cfg_if cfg_if ();

  ph_sensor_average_and_alarm #(.WINDOW(AVG_DEPTH)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sensor_item_t sensor_items[$];
  reading_t     due_readings[$];

  int errors = 0;
  int items_issued = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int settings_used = 1;
  int n_samples = 0;
  int n_checks = 0;
  int n_warns = 0;
  int n_notifies = 0;
  int peak_low = 0;

  logic in_accepted;
  logic cfg_accepted;

  // Predicted register and alarm state.
  logic [OFFSET_W-1:0] m_offset;
  logic [SLOPE_W-1:0]  m_slope;
  logic [PH_W-1:0]     m_warn;
  logic [PH_W-1:0]     m_ok;
  logic [PH_W-1:0]     m_cells[AVG_DEPTH];
  int                  m_wr;
  int                  m_fill;
  logic [18:0]         m_sum;
  logic [PH_W-1:0]     m_pub;
  logic [PH_W-1:0]     m_last;
  logic [PH_W-1:0]     m_prev;
  logic [LOWCNT_W-1:0] m_lowcnt;
  logic                m_pump;
  logic                m_first;

  task automatic clear_ph_state();
    m_offset = OFFSET_RST;
    m_slope  = SLOPE_RST;
    m_warn   = WARN_RST;
    m_ok     = OK_RST;
    foreach (m_cells[i]) m_cells[i] = '0;
    m_wr     = 0;
    m_fill   = 0;
    m_sum    = '0;
    m_pub    = '0;
    m_last   = '0;
    m_prev   = '0;
    m_lowcnt = '0;
    m_pump   = 1'b0;
    m_first  = 1'b1;
  endtask

  function automatic logic [PH_W-1:0] adc_to_ph_q10(input logic [CODE_W-1:0] code);
    longint unsigned volts, drop, q;
    volts = (longint'(VOLT_FULL_SCALE) * code) / ADC_FULL_SCALE;
    drop = m_slope;
    drop = drop * volts;
    if (drop >= m_offset) return '0;
    q = (m_offset - drop) >> 6;
    if (q > PH_MAX) q = PH_MAX;
    return PH_W'(q);
  endfunction

  task automatic advance_ph_state(input sensor_item_t entry, output reading_t rd);
    logic [PH_W-1:0] ph;
    logic            low, old_low;
    rd = '0;
    if (entry.op == OP_SAMPLE) begin
      ph = adc_to_ph_q10(entry.code);
      m_sum = m_sum - m_cells[m_wr] + ph;
      m_cells[m_wr] = ph;
      m_wr = (m_wr == AVG_DEPTH - 1) ? 0 : m_wr + 1;
      if (m_fill < AVG_DEPTH) m_fill++;
      m_last = ph;
      if (m_fill >= AVG_DEPTH) m_pub = PH_W'(m_sum / AVG_DEPTH);
      n_samples++;
    end else begin
      low = m_pub < m_warn;
      old_low = m_prev < m_warn;
      if (m_first && low) m_lowcnt = LOWCNT_W'(1);
      if (!old_low && low) m_lowcnt = LOWCNT_W'(1);
      if (old_low && low) begin
        if (m_lowcnt != LOWCNT_MAX) m_lowcnt++;
        if (m_lowcnt == 2 || m_lowcnt == 3) rd.warn = 1'b1;
        if (m_lowcnt == 3 && !m_pump) begin
          m_pump = 1'b1;
          rd.notify = 1'b1;
        end
      end
      if (m_pub > m_ok && m_pump) begin
        m_pump = 1'b0;
        rd.notify = 1'b1;
      end
      m_prev = m_pub;
      m_first = 1'b0;
      n_checks++;
      if (rd.warn) n_warns++;
      if (rd.notify) n_notifies++;
      if (m_lowcnt > peak_low) peak_low = m_lowcnt;
    end
    rd.avg    = m_pub;
    rd.avg_ok = (m_fill >= AVG_DEPTH);
    rd.latest = m_last;
    rd.pump   = m_pump;
  endtask

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    reading_t want, got;
    if (!rst_n) begin
      in_accepted <= 1'b0;
      cfg_accepted <= 1'b0;
    end else begin
      in_accepted <= in_if.valid && in_if.ready;
      cfg_accepted <= cfg_if.valid && cfg_if.ready;
      if (out_if.valid && out_if.ready) begin
        got = '{avg: out_if.ph_average, avg_ok: out_if.average_valid,
                latest: out_if.latest_ph, warn: out_if.warn_user,
                notify: out_if.notify_update, pump: out_if.pump_request};
        if (due_readings.size() == 0) begin
          $display("%0t ns: result transfer with nothing expected, actual %h", $time, got);
          errors++;
        end else begin
          want = due_readings.pop_front();
          check_field("ph_average", want.avg, got.avg);
          check_field("average_valid", want.avg_ok, got.avg_ok);
          check_field("latest_ph", want.latest, got.latest);
          check_field("warn_user", want.warn, got.warn);
          check_field("notify_update", want.notify, got.notify);
          check_field("pump_request", want.pump, got.pump);
          results_checked++;
        end
      end
      if (in_if.valid && in_if.ready) begin
        advance_ph_state('{op: in_if.opcode, code: in_if.adc_sample}, want);
        due_readings.push_back(want);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.addr)
          REG_PH_OFFSET:  m_offset = cfg_if.data[OFFSET_W-1:0];
          REG_PH_SLOPE:   m_slope = cfg_if.data[SLOPE_W-1:0];
          REG_WARN_LEVEL: m_warn = cfg_if.data[PH_W-1:0];
          REG_OK_LEVEL:   m_ok = cfg_if.data[PH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  int       burst_left = 0;
  int       gap_left = 0;
  int       rx_left = 0;
  rx_mode_t rx_mode = RX_EAGER;

  always @(negedge clk) begin : driver
    sensor_item_t nxt;
    if (rst_n) begin
      if (!in_if.valid || in_accepted) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (sensor_items.size() > 0) begin
          nxt = sensor_items.pop_front();
          in_if.valid <= 1'b1;
          in_if.opcode <= nxt.op;
          in_if.adc_sample <= nxt.code;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_EAGER:  out_if.ready <= 1'b1;
        RX_MOSTLY: out_if.ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
        default:   out_if.ready <= rx_left[2];
      endcase
    end
  end

  task automatic queue_item(input logic op, input logic [CODE_W-1:0] code);
    sensor_items.push_back('{op: op, code: code});
    items_issued++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.addr <= addr;
    cfg_if.data <= data;
    do @(negedge clk); while (!cfg_accepted);
    cfg_if.valid <= 1'b0;
    cfg_writes++;
  endtask

  // Bits above the slope and level registers' widths are filled with noise; the block must drop them.
  task automatic apply_setting(input logic [OFFSET_W-1:0] off, input logic [SLOPE_W-1:0] slp,
                               input logic [PH_W-1:0] wl, input logic [PH_W-1:0] okl);
    logic [CFG_DATA_W-1:0] data;
    write_reg(REG_PH_OFFSET, off);
    data = CFG_DATA_W'($urandom);
    data[SLOPE_W-1:0] = slp;
    write_reg(REG_PH_SLOPE, data);
    data = CFG_DATA_W'($urandom);
    data[PH_W-1:0] = wl;
    write_reg(REG_WARN_LEVEL, data);
    data = CFG_DATA_W'($urandom);
    data[PH_W-1:0] = okl;
    write_reg(REG_OK_LEVEL, data);
    settings_used++;
  endtask

  task automatic random_setting();
    logic [OFFSET_W-1:0] off;
    logic [SLOPE_W-1:0]  slp;
    logic [PH_W-1:0]     wl;
    int                  okl;
    if ($urandom_range(0, 1) == 1) begin
      off = OFFSET_W'($urandom_range(300000, 2500000));
      slp = SLOPE_W'($urandom_range(500, 12000));
    end else begin
      off = OFFSET_W'($urandom);
      slp = SLOPE_W'($urandom);
    end
    wl = PH_W'($urandom_range(0, PH_MAX));
    if ($urandom_range(0, 3) == 0) begin
      okl = $urandom_range(0, PH_MAX);
    end else begin
      okl = wl + $urandom_range(0, 1500);
      if (okl > 16383) okl = 16383;
    end
    apply_setting(off, slp, wl, PH_W'(okl));
  endtask

  function automatic logic [CODE_W-1:0] code_for_ph(input int target);
    longint off, v;
    if (m_slope == 0) return CODE_W'($urandom);
    if (target < 0) target = 0;
    off = m_offset;
    v = (off > longint'(target) * 64) ? (off - longint'(target) * 64) / m_slope : 0;
    if (v > VOLT_FULL_SCALE) v = VOLT_FULL_SCALE;
    v = v * ADC_FULL_SCALE / VOLT_FULL_SCALE + $urandom_range(0, 12);
    if (v > ADC_FULL_SCALE) v = ADC_FULL_SCALE;
    return CODE_W'(v);
  endfunction

  // Runs of samples steer the average toward a level near a threshold, a random level
  // or an end of the range, with checks and unrelated codes mixed in.
  task automatic build_items(input int count, input int check_pct);
    int left, seg, target;
    left = count;
    @(posedge clk);
    while (left > 0) begin
      seg = $urandom_range(5, 40);
      case ($urandom_range(0, 4))
        0: target = int'(m_warn) + int'($urandom_range(0, 600)) - 300;
        1: target = int'(m_ok) + int'($urandom_range(0, 600)) - 300;
        2: target = $urandom_range(0, PH_MAX);
        default: target = ($urandom_range(0, 1) == 1) ? int'(PH_MAX) : 0;
      endcase
      while (seg > 0 && left > 0) begin
        if ($urandom_range(0, 99) < check_pct) queue_item(OP_CHECK, CODE_W'($urandom));
        else if ($urandom_range(0, 9) == 0) queue_item(OP_SAMPLE, CODE_W'($urandom));
        else queue_item(OP_SAMPLE, code_for_ph(target + int'($urandom_range(0, 80)) - 40));
        seg--;
        left--;
      end
    end
  endtask

  task automatic wait_drained();
    while (results_checked != items_issued) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_SAMPLE;
    in_if.adc_sample = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = REG_PH_OFFSET;
    cfg_if.data = '0;
    clear_ph_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Checks before any sample see an average of zero, so the pump comes on.
    @(posedge clk);
    repeat (3) queue_item(OP_CHECK, '0);
    queue_item(OP_SAMPLE, 12'hFFF);
    queue_item(OP_SAMPLE, 12'h555);
    queue_item(OP_SAMPLE, 12'hAAA);
    queue_item(OP_SAMPLE, 12'h001);
    queue_item(OP_SAMPLE, 12'hFFE);
    repeat (15) queue_item(OP_SAMPLE, 12'h000);
    queue_item(OP_CHECK, 12'hFFF);
    queue_item(OP_SAMPLE, 12'h800);
    queue_item(OP_CHECK, 12'h7FF);
    wait_drained();

    apply_setting(OFFSET_RST, SLOPE_RST, WARN_RST, OK_RST);
    write_reg(CFG_ADDR_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
    build_items(250, 30);
    wait_drained();

    apply_setting('1, '0, '0, '0);
    build_items(100, 40);
    wait_drained();

    apply_setting('0, '1, '1, PH_MAX);
    build_items(100, 50);
    wait_drained();

    // Every check is low and the pump is never released, so the count saturates.
    apply_setting(OFFSET_RST, SLOPE_RST, '1, '1);
    build_items(300, 90);
    wait_drained();

    repeat (4) begin
      random_setting();
      if ($urandom_range(0, 1) == 1)
        write_reg(CFG_ADDR_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
      build_items(140, 30);
      wait_drained();
    end

    repeat (20) @(negedge clk);
    $display("Covered %0d samples and %0d alarm checks under %0d register settings (%0d writes).",
             n_samples, n_checks, settings_used, cfg_writes);
    $display("Saw %0d user warnings and %0d pump changes; the low-check count peaked at %0d.",
             n_warns, n_notifies, peak_low);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Run timed out with %0d of %0d results checked.", results_checked, items_issued);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
design/phsa_pkg.sv
design/phsa_ifs.sv
design/phsa_cell.sv
design/phsa_window.sv
design/phsa_alarm.sv
design/ph_sensor_average_and_alarm.sv
design/phsa_checker.sv
verif/tb_top.sv
